/* rtl/icfa_pkg.sv */
package icfa_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int REG_BITS   = 16;
  localparam int XW         = 64;

  localparam int B8  = (DATA_WIDTH < 8)  ? DATA_WIDTH : 8;
  localparam int B16 = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
  localparam int B32 = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2,
    OP_DIV = 3'd3, OP_MOD = 3'd4, OP_CMP = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    PR_EQ = 3'd0, PR_NE = 3'd1, PR_GT = 3'd2,
    PR_LT = 3'd3, PR_GE = 3'd4, PR_LE = 3'd5
  } pred_t;

  typedef enum logic [2:0] {
    WT_I1 = 3'd0, WT_I8 = 3'd1, WT_I16 = 3'd2, WT_I32 = 3'd3, WT_I64 = 3'd4
  } wtype_t;

  // Sideband that rides along the divider pipeline
  typedef struct packed {
    logic                ok;
    logic                is_div;
    logic                is_mod;
    logic                neg_q;
    logic                neg_r;
    logic [2:0]          rtype;
    logic [XW-1:0]       early;
    logic [REG_BITS-1:0] dreg;
  } side_t;

  // Sign-extend the low n bits of v
  function automatic logic [XW-1:0] sext_n(input logic [XW-1:0] v, input int n);
    logic [XW-1:0] t;
    t = v << (XW - n);
    return $signed(t) >>> (XW - n);
  endfunction

  // Narrow a result to its type
  function automatic logic [XW-1:0] narrow(input logic [XW-1:0] v, input logic [2:0] wt);
    logic [XW-1:0] r;
    case (wt)
      WT_I1:   r = {{(XW-1){1'b0}}, |sext_n(v, DATA_WIDTH)};
      WT_I8:   r = sext_n(v, B8);
      WT_I16:  r = sext_n(v, B16);
      WT_I32:  r = sext_n(v, B32);
      default: r = sext_n(v, DATA_WIDTH);
    endcase
    return r;
  endfunction

endpackage

/* rtl/icfa_div.sv */
module icfa_div
  import icfa_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [XW-1:0] dividend,
  input  logic [XW-1:0] divisor,
  input  side_t         in_side,
  output logic          out_valid,
  output logic [XW-1:0] quot,
  output logic [XW-1:0] rem,
  output side_t         out_side
);

  logic          vld  [0:XW];
  logic [XW-1:0] rr   [0:XW];
  logic [XW-1:0] dq   [0:XW];
  logic [XW-1:0] dv   [0:XW];
  side_t         sd   [0:XW];

  // Capture operands
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr[0] <= '0;
      dq[0] <= dividend;
      dv[0] <= divisor;
      sd[0] <= in_side;
    end
  end

  // One quotient bit per stage, restoring
  for (genvar i = 0; i < XW; i++) begin : g_stage
    logic [XW:0]   trial;
    logic [XW:0]   diff;
    logic          ge;

    assign trial = {rr[i], dq[i][XW-1]};
    assign diff  = trial - {1'b0, dv[i]};
    assign ge    = !diff[XW];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rr[i+1] <= ge ? diff[XW-1:0] : trial[XW-1:0];
        dq[i+1] <= {dq[i][XW-2:0], ge};
        dv[i+1] <= dv[i];
        sd[i+1] <= sd[i];
      end
    end
  end

  assign out_valid = vld[XW];
  assign quot      = dq[XW];
  assign rem       = rr[XW];
  assign out_side  = sd[XW];

endmodule

/* rtl/integer_constant_fold_alu.sv */
// Integer constant-fold ALU, fully pipelined.
// Input stream s_*: one operation per transfer; tuser carries the op,
// the compare predicate and the width type, tdata the two signed operands
// and the destination register. Output stream m_*: one result per input;
// tuser carries the folded flag and the result type, tdata the value and
// the register number.
// Depth: 68 register stages (input stage, operand/multiply stage, divider
// capture, 64 restoring divider stages, output register). Throughput: one
// transfer per cycle while the output is not stalled; every op runs the
// full depth so results leave in input order.
// The 64-stage divider sets the depth; the multiplier is split into three
// 32x32 partial products that are summed one stage later.
// Reset clears all valid bits; no result is pending afterwards.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; empty stages do not fill in while stalled. Nothing is
// lost or repeated.
module integer_constant_fold_alu
  import icfa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,  // lhs[63:0], rhs[127:64], target_reg[143:128]
  input  logic [8:0]   s_tuser,  // op[2:0], pred[5:3], width_type[8:6]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata,  // value[63:0], dest_reg[79:64]
  output logic [3:0]   m_tuser   // folded[0], value_type[3:1]
);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 0: capture the transfer
  logic                v0;
  logic [2:0]          op0, pred0, wt0;
  logic [XW-1:0]       a0, b0;
  logic [REG_BITS-1:0] reg0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0   <= s_tuser[2:0];
      pred0 <= s_tuser[5:3];
      wt0   <= s_tuser[8:6];
      a0    <= sext_n(s_tdata[63:0], DATA_WIDTH);
      b0    <= sext_n(s_tdata[127:64], DATA_WIDTH);
      reg0  <= s_tdata[128 +: REG_BITS];
    end
  end

  // Stage 1: add, sub, compare, partial products, magnitudes
  logic          slt_ab, slt_ba, eq_ab, cmp_r, arith, is_dm;
  logic [XW-1:0] early1_next;
  side_t         side1_next;

  always_comb begin
    eq_ab  = (a0 == b0);
    slt_ab = $signed(a0) < $signed(b0);
    slt_ba = $signed(b0) < $signed(a0);
    case (pred0)
      PR_EQ:   cmp_r = eq_ab;
      PR_NE:   cmp_r = !eq_ab;
      PR_GT:   cmp_r = slt_ba;
      PR_LT:   cmp_r = slt_ab;
      PR_GE:   cmp_r = !slt_ab;
      PR_LE:   cmp_r = !slt_ba;
      default: cmp_r = 1'b0;
    endcase
    case (op0)
      OP_ADD:  early1_next = a0 + b0;
      OP_SUB:  early1_next = a0 - b0;
      OP_CMP:  early1_next = {{(XW-1){1'b0}}, cmp_r};
      default: early1_next = '0;
    endcase
    is_dm = (op0 == OP_DIV) || (op0 == OP_MOD);
    arith = (op0 <= OP_MOD) && (wt0 <= WT_I64);
    side1_next.ok     = (op0 == OP_CMP) || (arith && !(is_dm && (b0 == '0)));
    side1_next.is_div = (op0 == OP_DIV);
    side1_next.is_mod = (op0 == OP_MOD);
    side1_next.neg_q  = a0[XW-1] ^ b0[XW-1];
    side1_next.neg_r  = a0[XW-1];
    side1_next.rtype  = (op0 == OP_CMP) ? 3'(WT_I1) : wt0;
    side1_next.early  = early1_next;
    side1_next.dreg   = reg0;
  end

  logic          v1, mul1;
  side_t         side1;
  logic [63:0]   p0;
  logic [31:0]   p1, p2;
  logic [XW-1:0] ma1, mb1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= side1_next;
      mul1  <= (op0 == OP_MUL);
      p0    <= a0[31:0] * b0[31:0];
      p1    <= 32'(a0[31:0] * b0[63:32]);
      p2    <= 32'(a0[63:32] * b0[31:0]);
      ma1   <= a0[XW-1] ? -a0 : a0;
      mb1   <= b0[XW-1] ? -b0 : b0;
    end
  end

  // Stage 2: sum partial products, enter the divider
  side_t side2;
  always_comb begin
    side2 = side1;
    if (mul1) begin
      side2.early = p0 + {p1 + p2, 32'd0};
    end
  end

  logic          dv_valid;
  logic [XW-1:0] quot, rem;
  side_t         dside;

  icfa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .dividend  (ma1),
    .divisor   (mb1),
    .in_side   (side2),
    .out_valid (dv_valid),
    .quot      (quot),
    .rem       (rem),
    .out_side  (dside)
  );

  // Final: sign fix, narrow, output register
  logic [XW-1:0] raw, val;
  always_comb begin
    if (dside.is_div) begin
      raw = dside.neg_q ? -quot : quot;
    end else if (dside.is_mod) begin
      raw = dside.neg_r ? -rem : rem;
    end else begin
      raw = dside.early;
    end
    val = narrow(raw, dside.rtype);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dside.ok) begin
        m_tdata <= {16'(dside.dreg), val};
        m_tuser <= {dside.rtype, 1'b1};
      end else begin
        m_tdata <= '0;
        m_tuser <= '0;
      end
    end
  end

endmodule
